// ===== sv/path_component_checker_top_assert.svh =====
// Assertion macros for the path component checker's checker file.
`ifndef PATH_COMPONENT_CHECKER_TOP_ASSERT_SVH
`define PATH_COMPONENT_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define PCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pcc_pkg.sv =====
// Types, codes and helper functions of the path component checker.
package pcc_pkg;

	typedef enum logic [2:0] {
		PH_START     = 3'd0,
		PH_SLASH     = 3'd1,
		PH_S_DOT     = 3'd2,
		PH_S_DOTDOT  = 3'd3,
		PH_PLAIN     = 3'd4,
		PH_SL_DOT    = 3'd5,
		PH_SL_DOTDOT = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		VD_OK       = 3'd0,
		VD_PIPE     = 3'd1,
		VD_CONTROL  = 3'd2,
		VD_DOT      = 3'd3,
		VD_DOTDOT   = 3'd4,
		VD_DBLSLASH = 3'd5,
		VD_EIGHTBIT = 3'd6
	} verdict_t;

	localparam logic KIND_OVERLONG = 1'b0;
	localparam logic KIND_8BIT     = 1'b1;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Per-string checker state.
	typedef struct packed {
		logic       err;
		verdict_t   code;
		logic       kind;
		logic [7:0] byte_val;
		phase_t     phase;
		logic [7:0] lead;
		logic       lead_v;
	} str_state_t;

	// One verdict as it leaves the block.
	typedef struct packed {
		verdict_t   code;
		logic       kind;
		logic [7:0] byte_val;
	} result_t;

	localparam str_state_t STATE_CLEAR = '{
		err: 1'b0, code: VD_OK, kind: 1'b0, byte_val: 8'h00,
		phase: PH_START, lead: 8'h00, lead_v: 1'b0
	};

	// A lead byte that may open an overlong sequence.
	function automatic logic is_lead(input logic [7:0] c);
		is_lead = (c & 8'hC2) == 8'hC0;
	endfunction

	function automatic logic is_overlong(input logic [7:0] lead, input logic [7:0] nxt);
		logic ovl;
		ovl = 1'b0;
		if (is_lead(lead) && ((nxt & 8'hC0) == 8'h80)) begin
			if ((lead & 8'h3E) == 8'h00)
				ovl = 1'b1;
			else if (lead == 8'hE0 && (nxt & 8'h20) == 8'h00)
				ovl = 1'b1;
			else if (lead == 8'hF0 && (nxt & 8'h30) == 8'h00)
				ovl = 1'b1;
			else if (lead == 8'hF8 && (nxt & 8'h38) == 8'h00)
				ovl = 1'b1;
			else if (lead == 8'hFC && (nxt & 8'h3C) == 8'h00)
				ovl = 1'b1;
		end
		is_overlong = ovl;
	endfunction

endpackage

// ===== sv/path_component_checker_top.sv =====
// Top level of the path component checker: input register, judge, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in      | to block  | in_valid / in_stall  | char_byte, last
//  out     | from block| out_valid / out_stall| verdict, eight_bit_kind, offending_byte
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_data (allow_eight_bit)
//
// One byte per cycle sustained while no last byte waits on a stalled result: a request
// sits in the input register, where the judge updates the string state in a single pass.
// A verdict goes from the judge into the result register when the string's last byte
// advances out of the input register.
// Reset (arst_n low) clears both valid bits, the string state and allow_eight_bit.
// A stalled result holds the result register; only a last byte then waits,
// other bytes keep flowing since they produce no result.
module path_component_checker_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] verdict,
	output logic       eight_bit_kind,
	output logic [7:0] offending_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	// configuration
	logic allow_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// string state and result register
	pcc_pkg::str_state_t state_q;
	pcc_pkg::str_state_t state_next;
	pcc_pkg::result_t    res;
	pcc_pkg::result_t    res_s2;
	logic                valid_s2;

	logic out_free;
	logic adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			allow_q <= 1'b0;
		else if (cfg_valid)
			allow_q <= cfg_data;
	end

	// The result register is free when empty or being drained this cycle.
	assign out_free = !valid_s2 || !out_stall;
	// Advance the held byte; only a last byte needs room for its verdict.
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !adv;

	// Load a new request whenever the input register is not held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= char_byte;
			last_s1 <= last;
		end
	end

	pcc_judge u_judge (
		.st              (state_q),
		.char_byte       (byte_s1),
		.last            (last_s1),
		.allow_eight_bit (allow_q),
		.st_next         (state_next),
		.res             (res)
	);

	// String state advances with each judged byte and clears after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pcc_pkg::STATE_CLEAR;
		else if (adv)
			state_q <= state_next;
	end

	// Result register: fill on a judged last byte, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv && last_s1)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1)
			res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign verdict        = res_s2.code;
	assign eight_bit_kind = res_s2.kind;
	assign offending_byte = res_s2.byte_val;

endmodule

// ===== sv/pcc_judge.sv =====
// Next-state and verdict logic for one byte of a path string.
module pcc_judge (
	input  pcc_pkg::str_state_t st,
	input  logic [7:0]          char_byte,
	input  logic                last,
	input  logic                allow_eight_bit,
	output pcc_pkg::str_state_t st_next,
	output pcc_pkg::result_t    res
);

	pcc_pkg::str_state_t ns;
	logic                done;

	always_comb begin
		ns   = st;
		done = 1'b0;

		if (!st.err) begin
			// settle a held lead byte against its follower
			if (st.lead_v) begin
				ns.lead_v = 1'b0;
				if (pcc_pkg::is_overlong(st.lead, char_byte)) begin
					ns.err      = 1'b1;
					ns.code     = pcc_pkg::VD_EIGHTBIT;
					ns.kind     = pcc_pkg::KIND_OVERLONG;
					ns.byte_val = st.lead;
					done        = 1'b1;
				end else if (!allow_eight_bit) begin
					ns.err      = 1'b1;
					ns.code     = pcc_pkg::VD_EIGHTBIT;
					ns.kind     = pcc_pkg::KIND_8BIT;
					ns.byte_val = st.lead;
					done        = 1'b1;
				end
			end

			// component tracking
			if (!done) begin
				if (char_byte == pcc_pkg::CH_SLASH) begin
					case (st.phase)
						pcc_pkg::PH_SLASH: begin
							ns.err = 1'b1; ns.code = pcc_pkg::VD_DBLSLASH;
							ns.kind = 1'b0; ns.byte_val = pcc_pkg::CH_SLASH;
							done = 1'b1;
						end
						pcc_pkg::PH_S_DOT, pcc_pkg::PH_SL_DOT: begin
							ns.err = 1'b1; ns.code = pcc_pkg::VD_DOT; ns.kind = 1'b0;
							ns.byte_val = (st.phase == pcc_pkg::PH_S_DOT) ?
								pcc_pkg::CH_DOT : pcc_pkg::CH_SLASH;
							done = 1'b1;
						end
						pcc_pkg::PH_S_DOTDOT, pcc_pkg::PH_SL_DOTDOT: begin
							ns.err = 1'b1; ns.code = pcc_pkg::VD_DOTDOT; ns.kind = 1'b0;
							ns.byte_val = (st.phase == pcc_pkg::PH_S_DOTDOT) ?
								pcc_pkg::CH_DOT : pcc_pkg::CH_SLASH;
							done = 1'b1;
						end
						default: ns.phase = pcc_pkg::PH_SLASH;
					endcase
				end else if (char_byte == pcc_pkg::CH_DOT) begin
					case (st.phase)
						pcc_pkg::PH_START:  ns.phase = pcc_pkg::PH_S_DOT;
						pcc_pkg::PH_SLASH:  ns.phase = pcc_pkg::PH_SL_DOT;
						pcc_pkg::PH_S_DOT:  ns.phase = pcc_pkg::PH_S_DOTDOT;
						pcc_pkg::PH_SL_DOT: ns.phase = pcc_pkg::PH_SL_DOTDOT;
						default:            ns.phase = pcc_pkg::PH_PLAIN;
					endcase
				end else begin
					ns.phase = pcc_pkg::PH_PLAIN;
				end
			end

			// the byte on its own
			if (!done) begin
				if (char_byte == pcc_pkg::CH_PIPE) begin
					ns.err = 1'b1; ns.code = pcc_pkg::VD_PIPE;
					ns.kind = 1'b0; ns.byte_val = char_byte;
				end else if (char_byte < pcc_pkg::CH_SPACE) begin
					ns.err = 1'b1; ns.code = pcc_pkg::VD_CONTROL;
					ns.kind = 1'b0; ns.byte_val = char_byte;
				end else if (char_byte[7]) begin
					if (pcc_pkg::is_lead(char_byte)) begin
						ns.lead   = char_byte;
						ns.lead_v = 1'b1;
					end else if (!allow_eight_bit) begin
						ns.err = 1'b1; ns.code = pcc_pkg::VD_EIGHTBIT;
						ns.kind = pcc_pkg::KIND_8BIT; ns.byte_val = char_byte;
					end
				end
			end
		end

		// end of string: settle what is still open
		if (last && !ns.err) begin
			if (ns.lead_v) begin
				if (!allow_eight_bit) begin
					ns.err = 1'b1; ns.code = pcc_pkg::VD_EIGHTBIT;
					ns.kind = pcc_pkg::KIND_8BIT; ns.byte_val = ns.lead;
				end
			end else if (ns.phase == pcc_pkg::PH_S_DOT || ns.phase == pcc_pkg::PH_SL_DOT) begin
				ns.err = 1'b1; ns.code = pcc_pkg::VD_DOT; ns.kind = 1'b0;
				ns.byte_val = (ns.phase == pcc_pkg::PH_S_DOT) ?
					pcc_pkg::CH_DOT : pcc_pkg::CH_SLASH;
			end else if (ns.phase == pcc_pkg::PH_S_DOTDOT ||
				ns.phase == pcc_pkg::PH_SL_DOTDOT) begin
				ns.err = 1'b1; ns.code = pcc_pkg::VD_DOTDOT; ns.kind = 1'b0;
				ns.byte_val = (ns.phase == pcc_pkg::PH_S_DOTDOT) ?
					pcc_pkg::CH_DOT : pcc_pkg::CH_SLASH;
			end
		end

		if (ns.err) begin
			res.code     = ns.code;
			res.kind     = (ns.code == pcc_pkg::VD_EIGHTBIT) ? ns.kind : 1'b0;
			res.byte_val = ns.byte_val;
		end else begin
			res.code     = pcc_pkg::VD_OK;
			res.kind     = 1'b0;
			res.byte_val = 8'h00;
		end

		st_next = last ? pcc_pkg::STATE_CLEAR : ns;
	end

endmodule

// ===== sv/pcc_checker.sv =====
// Port-level checks on the path component checker's result channel, with bind.
`include "path_component_checker_top_assert.svh"

module pcc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] verdict,
	input logic       eight_bit_kind,
	input logic [7:0] offending_byte
);

	// a clean string reports nothing else
	`PCC_ASSERT_NOW(a_ok_clean, out_valid && verdict == pcc_pkg::VD_OK,
		eight_bit_kind == 1'b0 && offending_byte == 8'h00, "ok verdict carries data")

	// kind only qualifies the eight-bit verdict
	`PCC_ASSERT_NOW(a_kind_only_8bit, out_valid && verdict != pcc_pkg::VD_EIGHTBIT,
		eight_bit_kind == 1'b0, "kind set on a non eight-bit verdict")

	// a dot component is reported at its opening slash or leading dot
	`PCC_ASSERT_NOW(a_dot_byte, out_valid && (verdict == pcc_pkg::VD_DOT || verdict == pcc_pkg::VD_DOTDOT),
		offending_byte == pcc_pkg::CH_SLASH || offending_byte == pcc_pkg::CH_DOT, "dot component byte wrong")

	// a double slash always points at a slash
	`PCC_ASSERT_NOW(a_dblslash_byte, out_valid && verdict == pcc_pkg::VD_DBLSLASH,
		offending_byte == pcc_pkg::CH_SLASH, "double slash byte wrong")

	// a stalled verdict holds
	`PCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(verdict) && $stable(offending_byte), "stalled result moved")

endmodule

bind path_component_checker_top pcc_checker u_pcc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.verdict        (verdict),
	.eight_bit_kind (eight_bit_kind),
	.offending_byte (offending_byte)
);

// ===== sim/path_component_checker_top_tb.sv =====
// Self-checking testbench for path_component_checker_top: byte stream in, verdict out.
`timescale 1ns / 1ps

module path_component_checker_top_tb;

	// Random part size, spacing of register writes, settle time before a write.
	localparam int RANDOM_BYTES = 1350;
	localparam int CFG_SPACING  = 170;
	localparam int SETTLE       = 4;
	localparam int CALM_BYTES   = 150;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {
		RQ_BYTE,
		RQ_CFG,
		RQ_DRAIN
	} req_op_t;

	// One pending request: a path byte, a register write, or a pause for drain.
	typedef struct {
		req_op_t    op;
		logic [7:0] data;
		logic       lst;
	} path_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] char_byte = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] verdict;
	logic       eight_bit_kind;
	logic [7:0] offending_byte;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;

	path_req_t          req_q[$];
	pcc_pkg::result_t   verdicts_due[$];
	int unsigned byte_total = 0;
	int unsigned bytes_taken = 0;
	int unsigned verdicts_seen = 0;
	int unsigned faults = 0;
	int unsigned cycles = 0;
	int unsigned in_gap = 0;
	int unsigned out_stall_left = 0;
	int unsigned quiet = 0;
	int unsigned in_idle_pct = 20;
	int unsigned out_idle_pct = 20;
	logic        calm = 1'b0;

	// Mirror of the checker: register copy and per-string state.
	logic              allow_8bit = 1'b0;
	logic              hit = 1'b0;
	pcc_pkg::verdict_t hit_code = pcc_pkg::VD_OK;
	logic              hit_kind = 1'b0;
	logic [7:0]        hit_byte = 8'h00;
	pcc_pkg::phase_t   comp_phase = pcc_pkg::PH_START;
	logic [7:0]        lead_byte = 8'h00;
	logic              lead_wait = 1'b0;

	path_component_checker_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_byte     (char_byte),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.eight_bit_kind(eight_bit_kind),
		.offending_byte(offending_byte),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// A byte that may open an overlong pair: top two bits set, bit 1 clear.
	function automatic logic lead_like(input logic [7:0] c);
		return c[7:6] == 2'b11 && !c[1];
	endfunction

	function automatic logic overlong_pair(input logic [7:0] ld, input logic [7:0] nx);
		if (!lead_like(ld) || nx[7:6] != 2'b10)
			return 1'b0;
		if (ld[5:1] == 5'd0)
			return 1'b1;
		case (ld)
			8'hE0: return nx[5] == 1'b0;
			8'hF0: return nx[5:4] == 2'd0;
			8'hF8: return nx[5:3] == 3'd0;
			8'hFC: return nx[5:2] == 4'd0;
			default: return 1'b0;
		endcase
	endfunction

	// Byte reported for a dot component: '.' at string start, else its slash.
	function automatic logic [7:0] opener(input pcc_pkg::phase_t p);
		return (p == pcc_pkg::PH_S_DOT || p == pcc_pkg::PH_S_DOTDOT) ?
			pcc_pkg::CH_DOT : pcc_pkg::CH_SLASH;
	endfunction

	function automatic logic is_dot(input pcc_pkg::phase_t p);
		return p == pcc_pkg::PH_S_DOT || p == pcc_pkg::PH_SL_DOT;
	endfunction

	function automatic logic is_dotdot(input pcc_pkg::phase_t p);
		return p == pcc_pkg::PH_S_DOTDOT || p == pcc_pkg::PH_SL_DOTDOT;
	endfunction

	task automatic note_fault(input pcc_pkg::verdict_t v, input logic k, input logic [7:0] b);
		hit      = 1'b1;
		hit_code = v;
		hit_kind = k;
		hit_byte = b;
	endtask

	task automatic judge_byte(input logic [7:0] c);
		pcc_pkg::phase_t p;
		p = comp_phase;
		// settle a held lead byte with its follower first
		if (lead_wait) begin
			lead_wait = 1'b0;
			if (overlong_pair(lead_byte, c)) begin
				note_fault(pcc_pkg::VD_EIGHTBIT, pcc_pkg::KIND_OVERLONG, lead_byte);
				return;
			end
			if (!allow_8bit) begin
				note_fault(pcc_pkg::VD_EIGHTBIT, pcc_pkg::KIND_8BIT, lead_byte);
				return;
			end
		end
		// a slash closes the current component
		if (c == pcc_pkg::CH_SLASH) begin
			if (p == pcc_pkg::PH_SLASH) begin
				note_fault(pcc_pkg::VD_DBLSLASH, 1'b0, pcc_pkg::CH_SLASH);
				return;
			end
			if (is_dot(p)) begin
				note_fault(pcc_pkg::VD_DOT, 1'b0, opener(p));
				return;
			end
			if (is_dotdot(p)) begin
				note_fault(pcc_pkg::VD_DOTDOT, 1'b0, opener(p));
				return;
			end
			comp_phase = pcc_pkg::PH_SLASH;
		end else if (c == pcc_pkg::CH_DOT) begin
			case (p)
				pcc_pkg::PH_START:  comp_phase = pcc_pkg::PH_S_DOT;
				pcc_pkg::PH_SLASH:  comp_phase = pcc_pkg::PH_SL_DOT;
				pcc_pkg::PH_S_DOT:  comp_phase = pcc_pkg::PH_S_DOTDOT;
				pcc_pkg::PH_SL_DOT: comp_phase = pcc_pkg::PH_SL_DOTDOT;
				default:            comp_phase = pcc_pkg::PH_PLAIN;
			endcase
		end else begin
			comp_phase = pcc_pkg::PH_PLAIN;
		end
		// then the byte on its own
		if (c == pcc_pkg::CH_PIPE) begin
			note_fault(pcc_pkg::VD_PIPE, 1'b0, c);
			return;
		end
		if (c < pcc_pkg::CH_SPACE) begin
			note_fault(pcc_pkg::VD_CONTROL, 1'b0, c);
			return;
		end
		if (c[7]) begin
			if (lead_like(c)) begin
				lead_byte = c;
				lead_wait = 1'b1;
			end else if (!allow_8bit) begin
				note_fault(pcc_pkg::VD_EIGHTBIT, pcc_pkg::KIND_8BIT, c);
			end
		end
	endtask

	// Advance the mirror by one accepted byte; queue a verdict on the last one.
	task automatic take_byte(input logic [7:0] c, input logic lst);
		pcc_pkg::result_t r;
		if (!hit)
			judge_byte(c);
		if (!lst)
			return;
		if (!hit) begin
			if (lead_wait) begin
				if (!allow_8bit)
					note_fault(pcc_pkg::VD_EIGHTBIT, pcc_pkg::KIND_8BIT, lead_byte);
			end else if (is_dot(comp_phase)) begin
				note_fault(pcc_pkg::VD_DOT, 1'b0, opener(comp_phase));
			end else if (is_dotdot(comp_phase)) begin
				note_fault(pcc_pkg::VD_DOTDOT, 1'b0, opener(comp_phase));
			end
		end
		if (hit)
			r = '{code: hit_code,
				kind: (hit_code == pcc_pkg::VD_EIGHTBIT) ? hit_kind : 1'b0,
				byte_val: hit_byte};
		else
			r = '{code: pcc_pkg::VD_OK, kind: 1'b0, byte_val: 8'h00};
		verdicts_due.push_back(r);
		hit        = 1'b0;
		hit_code   = pcc_pkg::VD_OK;
		hit_kind   = 1'b0;
		hit_byte   = 8'h00;
		comp_phase = pcc_pkg::PH_START;
		lead_byte  = 8'h00;
		lead_wait  = 1'b0;
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic int unsigned pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 8;
			2: return 25;
			default: return 50;
		endcase
	endfunction

	task automatic push_cfg(input logic v);
		req_q.push_back('{op: RQ_CFG, data: {7'd0, v}, lst: 1'b0});
	endtask

	// Queue one whole path string, flagging its final byte.
	task automatic commit_text(input logic [7:0] txt[$]);
		foreach (txt[i]) begin
			req_q.push_back('{op: RQ_BYTE, data: txt[i], lst: i == txt.size() - 1});
			byte_total++;
		end
	endtask

	task automatic add_text(input string s);
		logic [7:0] txt[$];
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
		commit_text(txt);
	endtask

	function automatic logic [7:0] pick_lead();
		case ($urandom_range(0, 7))
			0: return 8'hC0;
			1: return 8'hC1;
			2: return 8'hE0;
			3: return 8'hF0;
			4: return 8'hF8;
			5: return 8'hFC;
			default: return {2'b11, 6'($urandom_range(0, 63))} & 8'hFD;
		endcase
	endfunction

	// Mostly path-like characters; noisy strings add the troublemakers.
	function automatic logic [7:0] pick_char(input logic noisy);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 8'h61 + 8'($urandom_range(0, 25));
		if (r < 62)
			return pcc_pkg::CH_SLASH;
		if (r < 80)
			return pcc_pkg::CH_DOT;
		if (!noisy)
			return 8'($urandom_range(8'h21, 8'h7E));
		if (r < 84)
			return pcc_pkg::CH_PIPE;
		if (r < 87)
			return 8'($urandom_range(0, 31));
		if (r < 93)
			return pick_lead();
		if (r < 97)
			return 8'h80 | 8'($urandom_range(0, 63));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_random_path();
		logic [7:0] txt[$];
		logic       noisy;
		int unsigned len;
		logic [7:0] c;
		noisy = $urandom_range(0, 99) < 45;
		len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 10);
		while (txt.size() < len) begin
			c = pick_char(noisy);
			txt.push_back(c);
			// give most lead bytes a continuation so overlong pairs form
			if (lead_like(c) && txt.size() < len && $urandom_range(0, 99) < 60)
				txt.push_back(8'h80 | 8'($urandom_range(0, 63)));
		end
		commit_text(txt);
	endtask

	initial begin : stimulus
		logic [7:0] raw[$];
		int unsigned next_cfg;
		logic drained;

		// directed strings, 8-bit bytes refused (reset value)
		add_text("/");
		add_text(".");
		add_text("..");
		add_text("a//");
		add_text("a|");
		add_text("/./x");
		raw = {8'h00};
		commit_text(raw);
		raw = {8'hFF};
		commit_text(raw);
		raw = {8'hC0, 8'h80};
		commit_text(raw);
		// lead byte that ends the string: refused only as 8-bit
		raw = {8'hE0};
		commit_text(raw);
		// 8-bit allowed: only overlong pairs fail
		push_cfg(1'b1);
		raw = {8'hE0, 8'h80};
		commit_text(raw);
		raw = {8'hF0, 8'h8F};
		commit_text(raw);
		raw = {8'hFC, 8'h83};
		commit_text(raw);
		raw = {8'hC3};
		commit_text(raw);

		// random part, register rewritten with a random value between phases, one full drain midway
		next_cfg = byte_total + CFG_SPACING;
		drained = 1'b0;
		push_cfg(1'b0);
		while (byte_total < RANDOM_BYTES + 25) begin
			add_random_path();
			if (byte_total >= next_cfg) begin
				push_cfg(1'($urandom_range(0, 1)));
				next_cfg += CFG_SPACING;
			end
			if (!drained && byte_total >= RANDOM_BYTES / 2) begin
				req_q.push_back('{op: RQ_DRAIN, data: 8'h00, lst: 1'b0});
				drained = 1'b1;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// hold until every request is taken and every verdict is back
		while (req_q.size() != 0 || in_valid || cfg_valid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("path_component_checker_top_tb: PASS");
		else
			$display("path_component_checker_top_tb: FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin : driver
		logic       nv;
		logic [7:0] nb;
		logic       nl;
		logic       ncv;
		logic       ncd;
		path_req_t  head;
		nv  = in_valid;
		nb  = char_byte;
		nl  = last;
		ncv = cfg_valid;
		ncd = cfg_data;
		if (arst_n) begin
			// retire an accepted byte request and maybe open an idle burst
			if (in_valid && !in_stall) begin
				take_byte(char_byte, last);
				bytes_taken++;
				nv = 1'b0;
				calm = bytes_taken + CALM_BYTES >= byte_total;
				if (bytes_taken % 128 == 0)
					in_idle_pct = pick_pct();
				if (!calm && $urandom_range(0, 99) < in_idle_pct)
					in_gap = $urandom_range(1, 14);
			end
			if (cfg_valid && cfg_ready) begin
				allow_8bit = cfg_data;
				ncv = 1'b0;
			end
			// count cycles with nothing in flight; writes and drains wait on it
			if (!in_valid && !cfg_valid && !out_valid && verdicts_due.size() == 0)
				quiet++;
			else
				quiet = 0;
			if (!nv && !ncv) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (req_q.size() != 0) begin
					head = req_q[0];
					case (head.op)
						RQ_BYTE: begin
							nv = 1'b1;
							nb = head.data;
							nl = head.lst;
							void'(req_q.pop_front());
						end
						RQ_CFG: if (quiet >= SETTLE) begin
							ncv = 1'b1;
							ncd = head.data[0];
							quiet = 0;
							void'(req_q.pop_front());
						end
						default: if (quiet >= SETTLE) begin
							void'(req_q.pop_front());
						end
					endcase
				end
			end
		end
		in_valid  <= nv;
		char_byte <= nb;
		last      <= nl;
		cfg_valid <= ncv;
		cfg_data  <= ncd;
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : monitor
		pcc_pkg::result_t want;
		logic             ns;
		ns = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				verdicts_seen++;
				if (verdicts_due.size() == 0) begin
					$display("%0t: verdict expected none actual %0d kind %0d byte %h",
						$time, verdict, eight_bit_kind, offending_byte);
					faults++;
				end else begin
					want = verdicts_due.pop_front();
					if (verdict !== want.code) begin
						$display("%0t: verdict expected %0d actual %0d", $time,
							want.code, verdict);
						faults++;
					end
					if (eight_bit_kind !== want.kind) begin
						$display("%0t: eight_bit_kind expected %0d actual %0d", $time,
							want.kind, eight_bit_kind);
						faults++;
					end
					if (offending_byte !== want.byte_val) begin
						$display("%0t: offending_byte expected %h actual %h", $time,
							want.byte_val, offending_byte);
						faults++;
					end
				end
				if (verdicts_seen % 16 == 0)
					out_idle_pct = pick_pct();
			end
			// stall in random bursts, none started near the end
			if (out_stall_left > 0) begin
				out_stall_left--;
				ns = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
				ns = 1'b1;
				out_stall_left = $urandom_range(0, 13);
			end
		end
		out_stall <= ns;
	end

	// Drop the run if it hangs.
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("path_component_checker_top_tb: FAIL");
			$finish;
		end
	end

endmodule
